// File: rtl/can_frame_to_slcan_text_encoder_top_macros.svh
// Assertion helpers, sampled on clk, off while rst_n is low
`ifndef CAN_FRAME_TO_SLCAN_TEXT_ENCODER_TOP_MACROS_SVH
`define CAN_FRAME_TO_SLCAN_TEXT_ENCODER_TOP_MACROS_SVH

`define SLCAN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SLCAN_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/slcan_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slcan_pkg;

    localparam int unsigned TIMER_WRAP_DEF      = 60000;
    localparam int unsigned TX_BUFFER_BYTES_DEF = 512;

    localparam int unsigned ID_W      = 11;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned FREE_W    = 10;
    localparam int unsigned TS_W      = 16;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned MAX_BYTES = 8;

    localparam logic [CHAR_W-1:0] CHAR_T    = 8'h74;
    localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;
    localparam logic [3:0]        HEX_TEN   = 4'd10;
    localparam logic [3:0]        NIB_MASK  = 4'hF;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        logic [FREE_W-1:0] tx_free;
    } frame_t;

    typedef struct packed {
        logic tick;
        logic enable;
    } ts_ctrl_t;

    typedef enum logic [2:0] {
        ENC_IDLE,
        ENC_START,
        ENC_BODY,
        ENC_STAMP,
        ENC_END,
        ENC_DROP
    } enc_state_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
        logic [3:0] n;
        n = v & NIB_MASK;
        if (n >= HEX_TEN)
        begin
            return CHAR_A + CHAR_W'(n - HEX_TEN);
        end
        return CHAR_0 + CHAR_W'(n);
    endfunction

endpackage

`default_nettype wire

// File: rtl/can_frame_to_slcan_text_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake        Payload
// s_axis    in   tvalid / tready  tdata: elapsed_ms, frame_id, frame_len, frame_data,
//                                 tx_free; tuser: opcode (1 = frame)
// m_axis    out  tvalid / tready  tdata: out_char; tlast: last_char; tuser: dropped
// cfg       in   cfg_wr_en        cfg_wr_data: timestamp_enable
//
// A frame is loaded, then its characters are sent at the output pace; a dropped frame
// sends a single drop transfer. Characters come from a nibble shift register.
// A tick zeroes the timestamp when off, else adds elapsed_ms (bit-serial mod TIMER_WRAP).
// Input is taken while the last character still waits in the output register.
// Reset is asynchronous and clears the counter and the enable; no clearing pass.

module can_frame_to_slcan_text_encoder_top #(
    parameter int unsigned TIMER_WRAP      = slcan_pkg::TIMER_WRAP_DEF,
    parameter int unsigned TX_BUFFER_BYTES = slcan_pkg::TX_BUFFER_BYTES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] elapsed_ms, [26:16] frame_id, [30:27] frame_len,
    // [94:31] frame_data, [104:95] tx_free, [111:105] zero
    input  wire logic [111:0] s_axis_tdata,
    // [0] opcode
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [7:0] out_char
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast,
    // [0] dropped
    output logic              m_axis_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_data
);
    import slcan_pkg::*;

    logic            ts_en_reg;
    logic            accept;
    logic            enc_idle;
    logic            ts_busy;
    logic [TS_W-1:0] ts_val;
    frame_t          frame;
    ts_ctrl_t        ts_ctrl;

    assign s_axis_tready = enc_idle && !ts_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign frame.id      = s_axis_tdata[26:16];
    assign frame.len     = s_axis_tdata[30:27];
    assign frame.data    = s_axis_tdata[94:31];
    assign frame.tx_free = s_axis_tdata[104:95];

    assign ts_ctrl.tick   = accept && !s_axis_tuser;
    assign ts_ctrl.enable = ts_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            ts_en_reg <= cfg_wr_data;
        end
    end

    slcan_ts_timer #(
        .TIMER_WRAP (TIMER_WRAP)
    ) u_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ts_ctrl),
        .elapsed_ms   (s_axis_tdata[15:0]),
        .busy         (ts_busy),
        .timestamp_ms (ts_val)
    );

    slcan_txt_ser #(
        .TX_BUFFER_BYTES (TX_BUFFER_BYTES)
    ) u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept && s_axis_tuser),
        .frame        (frame),
        .ts_en        (ts_en_reg),
        .timestamp_ms (ts_val),
        .idle         (enc_idle),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_char     (m_axis_tdata),
        .out_last     (m_axis_tlast),
        .out_drop     (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/slcan_ts_timer.sv
`timescale 1ns / 1ps
`default_nettype none

`include "can_frame_to_slcan_text_encoder_top_macros.svh"

module slcan_ts_timer #(
    parameter int unsigned TIMER_WRAP = slcan_pkg::TIMER_WRAP_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire slcan_pkg::ts_ctrl_t        ctrl,
    input  wire logic [slcan_pkg::TS_W-1:0] elapsed_ms,
    output logic                            busy,
    output logic [slcan_pkg::TS_W-1:0]      timestamp_ms
);
    import slcan_pkg::*;

    localparam int unsigned SUM_W = TS_W + 1;
    localparam int unsigned CNT_W = $clog2(SUM_W + 1);
    localparam logic [SUM_W-1:0] WRAP_VAL = SUM_W'(TIMER_WRAP);

    logic [TS_W-1:0]  ts_reg,   ts_next;
    logic [SUM_W-1:0] sum_reg,  sum_next;
    logic [SUM_W-1:0] rem_reg,  rem_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic [SUM_W-1:0] rem_shift;

    // restoring reduction mod TIMER_WRAP, one sum bit per cycle, MSB first
    always_comb
    begin
        rem_shift = {rem_reg[SUM_W-2:0], sum_reg[SUM_W-1]};
        if (rem_shift >= WRAP_VAL)
        begin
            rem_shift = rem_shift - WRAP_VAL;
        end
    end

    always_comb
    begin
        ts_next   = ts_reg;
        sum_next  = sum_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            sum_next = {sum_reg[SUM_W-2:0], 1'b0};
            rem_next = rem_shift;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                ts_next   = rem_shift[TS_W-1:0];
            end
        end
        else if (ctrl.tick)
        begin
            if (ctrl.enable)
            begin
                sum_next  = {1'b0, ts_reg} + {1'b0, elapsed_ms};
                rem_next  = '0;
                cnt_next  = CNT_W'(SUM_W);
                busy_next = 1'b1;
            end
            else
            begin
                ts_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg   <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            ts_reg   <= ts_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        rem_reg <= rem_next;
    end

    assign busy         = busy_reg;
    assign timestamp_ms = ts_reg;

    `SLCAN_ASSERT(a_busy_cnt, busy_reg |-> (cnt_reg != '0), "reduction running with zero count")
    `SLCAN_ASSERT(a_ts_range, !busy_reg |-> ({1'b0, ts_reg} < WRAP_VAL), "timestamp beyond wrap")
    `SLCAN_ASSERT_NEVER(a_tick_busy, ctrl.tick && busy_reg, "tick while reduction running")

endmodule

`default_nettype wire

// File: rtl/slcan_txt_ser.sv
`timescale 1ns / 1ps
`default_nettype none

`include "can_frame_to_slcan_text_encoder_top_macros.svh"

module slcan_txt_ser #(
    parameter int unsigned TX_BUFFER_BYTES = slcan_pkg::TX_BUFFER_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire slcan_pkg::frame_t            frame,
    input  wire logic                         ts_en,
    input  wire logic [slcan_pkg::TS_W-1:0]   timestamp_ms,
    output logic                              idle,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [slcan_pkg::CHAR_W-1:0]      out_char,
    output logic                              out_last,
    output logic                              out_drop
);
    import slcan_pkg::*;

    localparam int unsigned BODY_NIBS = 4 + 2 * MAX_BYTES;
    localparam int unsigned BODY_W    = 4 * BODY_NIBS;
    localparam int unsigned BCNT_W    = $clog2(BODY_NIBS + 1);
    localparam int unsigned SCNT_W    = 3;
    localparam int unsigned CMP_W     = 17;
    localparam logic [CMP_W-1:0] BUF_MAX = CMP_W'(TX_BUFFER_BYTES);

    enc_state_t state_reg, state_next;

    logic [BODY_W-1:0] body_reg,  body_next;
    logic [BCNT_W-1:0] bcnt_reg,  bcnt_next;
    logic [TS_W-1:0]   stamp_reg, stamp_next;
    logic [SCNT_W-1:0] scnt_reg,  scnt_next;

    logic              ov_reg,    ov_next;
    logic [CHAR_W-1:0] char_reg,  char_next;
    logic              last_reg,  last_next;
    logic              drop_reg,  drop_next;

    logic              adv;
    logic [LEN_W-1:0]  nbytes;
    logic [4:0]        need;
    logic [CMP_W-1:0]  free_sat;
    logic              no_room;
    logic [BODY_W-1:0] body_load;

    assign adv = !ov_reg || out_ready;

    always_comb
    begin
        nbytes = (frame.len > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : frame.len;
        need   = 5'd6 + {nbytes, 1'b0} + (ts_en ? 5'd4 : 5'd0);
        free_sat = ({7'b0, frame.tx_free} > BUF_MAX) ? BUF_MAX : {7'b0, frame.tx_free};
        no_room  = free_sat < {12'b0, need};
        body_load = '0;
        body_load[BODY_W-1 -: 16] = {1'b0, frame.id, frame.len};
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            body_load[DATA_W-1-8*i -: 8] = frame.data[8*i +: 8];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENC_IDLE:
            begin
                if (start)
                begin
                    state_next = no_room ? ENC_DROP : ENC_START;
                end
            end
            ENC_START:
            begin
                if (adv)
                begin
                    state_next = ENC_BODY;
                end
            end
            ENC_BODY:
            begin
                if (adv && bcnt_reg == BCNT_W'(1))
                begin
                    state_next = (scnt_reg != '0) ? ENC_STAMP : ENC_END;
                end
            end
            ENC_STAMP:
            begin
                if (adv && scnt_reg == SCNT_W'(1))
                begin
                    state_next = ENC_END;
                end
            end
            ENC_END, ENC_DROP:
            begin
                if (adv)
                begin
                    state_next = ENC_IDLE;
                end
            end
            default:
            begin
                state_next = ENC_IDLE;
            end
        endcase
    end

    always_comb
    begin
        body_next  = body_reg;
        bcnt_next  = bcnt_reg;
        stamp_next = stamp_reg;
        scnt_next  = scnt_reg;
        ov_next    = ov_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        drop_next  = drop_reg;
        case (state_reg)
            ENC_IDLE:
            begin
                if (start)
                begin
                    body_next  = body_load;
                    bcnt_next  = BCNT_W'(5'd4 + {nbytes, 1'b0});
                    stamp_next = timestamp_ms;
                    scnt_next  = ts_en ? SCNT_W'(4) : '0;
                end
            end
            ENC_START:
            begin
                if (adv)
                begin
                    ov_next   = 1'b1;
                    char_next = CHAR_T;
                    last_next = 1'b0;
                    drop_next = 1'b0;
                end
            end
            ENC_BODY:
            begin
                if (adv)
                begin
                    ov_next   = 1'b1;
                    char_next = hex_char(body_reg[BODY_W-1 -: 4]);
                    last_next = 1'b0;
                    drop_next = 1'b0;
                    body_next = {body_reg[BODY_W-5:0], 4'h0};
                    bcnt_next = bcnt_reg - 1'b1;
                end
            end
            ENC_STAMP:
            begin
                if (adv)
                begin
                    ov_next    = 1'b1;
                    char_next  = hex_char(stamp_reg[TS_W-1 -: 4]);
                    last_next  = 1'b0;
                    drop_next  = 1'b0;
                    stamp_next = {stamp_reg[TS_W-5:0], 4'h0};
                    scnt_next  = scnt_reg - 1'b1;
                end
            end
            ENC_END:
            begin
                if (adv)
                begin
                    ov_next   = 1'b1;
                    char_next = CHAR_CR;
                    last_next = 1'b1;
                    drop_next = 1'b0;
                end
            end
            ENC_DROP:
            begin
                if (adv)
                begin
                    ov_next   = 1'b1;
                    char_next = CHAR_NONE;
                    last_next = 1'b1;
                    drop_next = 1'b1;
                end
            end
            default:
            begin
                ov_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENC_IDLE;
            ov_reg    <= 1'b0;
            bcnt_reg  <= '0;
            scnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            bcnt_reg  <= bcnt_next;
            scnt_reg  <= scnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg  <= body_next;
        stamp_reg <= stamp_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        drop_reg  <= drop_next;
    end

    assign idle      = (state_reg == ENC_IDLE);
    assign out_valid = ov_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_drop  = drop_reg;

    `SLCAN_ASSERT(a_drop_form, (ov_reg && drop_reg) |-> (last_reg && char_reg == CHAR_NONE), "malformed drop transfer")
    `SLCAN_ASSERT(a_body_cnt, (state_reg == ENC_BODY) |-> (bcnt_reg != '0), "body digits exhausted")
    `SLCAN_ASSERT_NEVER(a_start_busy, start && state_reg != ENC_IDLE, "frame started while busy")

endmodule

`default_nettype wire
